[hw/rtl/lzw_pkg.sv]
// Shared types and constants of the LZW decoder: code and length widths,
// dictionary entry layout and the job record passed to the byte emitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lzw_pkg;

  localparam int unsigned CODE_W       = 12;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned DICT_ENTRIES = 4096;
  localparam int unsigned NFC_W        = CODE_W + 1;
  localparam int unsigned LIT_CODES    = 256;
  localparam int unsigned MAX_LEN      = 64;
  localparam int unsigned LEN_W        = $clog2(MAX_LEN + 2);
  localparam int unsigned IDX_W        = $clog2(MAX_LEN);
  localparam int unsigned STK_AW       = IDX_W + 1;
  localparam int unsigned STK_DEPTH    = 2 * MAX_LEN;
  localparam int unsigned S_TDATA_W    = ((CODE_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W    = ((BYTE_W + 7) / 8) * 8;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef struct packed {
    code_t              prefix;
    logic [BYTE_W-1:0]  suffix;
    len_t               len;
  } lzw_entry_t;

  localparam int unsigned ENTRY_W = $bits(lzw_entry_t);

  typedef struct packed {
    logic err;
    logic bank;
    idx_t last_idx;
  } lzw_job_t;

endpackage

`default_nettype wire

[hw/rtl/lzw_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lzw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/lzw_walker.sv]
// Code decode and prefix-chain walk: owns the dictionary RAM, fills one bank of
// the byte stack per good code and hands a job (or an error job) to the emitter. Depends on lzw_pkg, lzw_ram.
`timescale 1ns / 1ps
`default_nettype none

module lzw_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lzw_pkg::code_t              code_i,
  input  logic                        start_i,
  output logic                        stk_we_o,
  output logic [lzw_pkg::STK_AW-1:0]  stk_waddr_o,
  output logic [lzw_pkg::BYTE_W-1:0]  stk_wdata_o,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output lzw_pkg::lzw_job_t           job_o
);
  import lzw_pkg::*;

  typedef enum logic [2:0] {W_IDLE, W_LEN, W_KW, W_WALK, W_HAND} state_e;

  state_e            state_q;
  logic [NFC_W-1:0]  nfc_q;
  logic              hp_q;
  code_t             prev_q;
  logic [BYTE_W-1:0] pfb_q;
  len_t              prev_len_q;
  code_t             code_q;
  code_t             p_q;
  idx_t              idx_q;
  len_t              len_q;
  logic              err_q;
  logic              bank_q;

  logic [NFC_W-1:0]  nfc_e;
  logic              hp_e;
  logic              is_lit;
  logic              is_def;
  logic              is_kw;
  logic              kw_fits;
  logic              room;
  logic              p_lit;
  logic              walk_end;
  lzw_entry_t        rd_entry;
  lzw_entry_t        wr_entry;
  logic [BYTE_W-1:0] walk_byte;
  logic              dict_we;
  code_t             dict_raddr;
  logic [ENTRY_W-1:0] dict_rdata;

  lzw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DICT_ENTRIES)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (nfc_q[CODE_W-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (dict_raddr),
    .rdata_o (dict_rdata)
  );

  always_comb begin
    nfc_e     = start_i ? NFC_W'(LIT_CODES) : nfc_q;
    hp_e      = hp_q & ~start_i;
    is_lit    = code_i < CODE_W'(LIT_CODES);
    is_def    = {1'b0, code_i} < nfc_e;
    is_kw     = hp_e && ({1'b0, code_i} == nfc_e) && (nfc_e < NFC_W'(DICT_ENTRIES));
    kw_fits   = prev_len_q < LEN_W'(MAX_LEN);
    room      = nfc_q < NFC_W'(DICT_ENTRIES);
    p_lit     = p_q < CODE_W'(LIT_CODES);
    rd_entry  = lzw_entry_t'(dict_rdata);
    walk_byte = p_lit ? p_q[BYTE_W-1:0] : rd_entry.suffix;
    walk_end  = (state_q == W_WALK) && (idx_q == '0);

    wr_entry.prefix = prev_q;
    wr_entry.suffix = walk_byte;
    wr_entry.len    = prev_len_q + LEN_W'(1);
    dict_we         = walk_end && hp_q && room;

    case (state_q)
      W_IDLE:  dict_raddr = is_kw ? prev_q : code_i;
      W_WALK:  dict_raddr = rd_entry.prefix;
      default: dict_raddr = p_q;
    endcase

    stk_we_o    = (state_q == W_KW) || (state_q == W_WALK);
    stk_waddr_o = (state_q == W_KW) ? {bank_q, IDX_W'(len_q - LEN_W'(1))} : {bank_q, idx_q};
    stk_wdata_o = (state_q == W_KW) ? pfb_q : walk_byte;

    in_ready_o     = state_q == W_IDLE;
    job_valid_o    = state_q == W_HAND;
    job_o.err      = err_q;
    job_o.bank     = bank_q;
    job_o.last_idx = IDX_W'(len_q - LEN_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= W_IDLE;
      nfc_q      <= NFC_W'(LIT_CODES);
      hp_q       <= 1'b0;
      prev_q     <= '0;
      pfb_q      <= '0;
      prev_len_q <= '0;
      code_q     <= '0;
      p_q        <= '0;
      idx_q      <= '0;
      len_q      <= '0;
      err_q      <= 1'b0;
      bank_q     <= 1'b0;
    end else begin
      case (state_q)
        W_IDLE: begin
          if (in_valid_i) begin
            nfc_q  <= nfc_e;
            hp_q   <= hp_e;
            code_q <= code_i;
            err_q  <= 1'b0;
            if (is_lit) begin
              p_q     <= code_i;
              idx_q   <= '0;
              len_q   <= LEN_W'(1);
              state_q <= W_WALK;
            end else if (!hp_e) begin
              err_q   <= 1'b1;
              state_q <= W_HAND;
            end else if (is_def) begin
              p_q     <= code_i;
              state_q <= W_LEN;
            end else if (is_kw && kw_fits) begin
              p_q     <= prev_q;
              len_q   <= prev_len_q + LEN_W'(1);
              state_q <= W_KW;
            end else begin
              err_q   <= 1'b1;
              state_q <= W_HAND;
            end
          end
        end
        W_LEN: begin
          if (rd_entry.len > LEN_W'(MAX_LEN)) begin
            err_q   <= 1'b1;
            state_q <= W_HAND;
          end else begin
            len_q   <= rd_entry.len;
            idx_q   <= IDX_W'(rd_entry.len - LEN_W'(1));
            state_q <= W_WALK;
          end
        end
        W_KW: begin
          // last byte already placed, walk the previous string below it
          idx_q   <= IDX_W'(len_q - LEN_W'(2));
          state_q <= W_WALK;
        end
        W_WALK: begin
          if (!p_lit) begin
            p_q <= rd_entry.prefix;
          end
          if (walk_end) begin
            if (hp_q && room) begin
              nfc_q <= nfc_q + NFC_W'(1);
            end
            prev_q     <= code_q;
            pfb_q      <= walk_byte;
            hp_q       <= 1'b1;
            prev_len_q <= len_q;
            state_q    <= W_HAND;
          end else begin
            idx_q <= idx_q - IDX_W'(1);
          end
        end
        W_HAND: begin
          if (job_ready_i) begin
            bank_q  <= ~bank_q;
            state_q <= W_IDLE;
          end
        end
        default: state_q <= W_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lzw_emitter.sv]
// Byte emitter: reads one stack bank front to back into the output register,
// or gives the single error beat. Depends on lzw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lzw_emitter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  output logic                        job_ready_o,
  input  lzw_pkg::lzw_job_t           job_i,
  output logic [lzw_pkg::STK_AW-1:0]  stk_raddr_o,
  input  logic [lzw_pkg::BYTE_W-1:0]  stk_rdata_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [lzw_pkg::BYTE_W-1:0]  m_data_o,
  output logic                        m_last_o,
  output logic                        m_err_o
);
  import lzw_pkg::*;

  typedef enum logic {E_IDLE, E_RUN} state_e;

  state_e            state_q;
  logic              bank_q;
  idx_t              last_idx_q;
  logic              err_q;
  idx_t              j_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_data_q;
  logic              out_last_q;
  logic              out_err_q;

  logic              load;
  logic              at_end;
  idx_t              j_next;

  always_comb begin
    load        = (state_q == E_RUN) && (!out_valid_q || m_ready_i);
    at_end      = err_q || (j_q == last_idx_q);
    j_next      = load ? j_q + IDX_W'(1) : j_q;
    stk_raddr_o = (state_q == E_IDLE) ? {job_i.bank, IDX_W'(0)} : {bank_q, j_next};
    job_ready_o = state_q == E_IDLE;
    m_valid_o   = out_valid_q;
    m_data_o    = out_data_q;
    m_last_o    = out_last_q;
    m_err_o     = out_err_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= E_IDLE;
      bank_q      <= 1'b0;
      last_idx_q  <= '0;
      err_q       <= 1'b0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      case (state_q)
        E_IDLE: begin
          if (job_valid_i) begin
            bank_q     <= job_i.bank;
            last_idx_q <= job_i.last_idx;
            err_q      <= job_i.err;
            j_q        <= '0;
            state_q    <= E_RUN;
          end
        end
        E_RUN: begin
          if (load) begin
            if (at_end) begin
              state_q <= E_IDLE;
            end else begin
              j_q <= j_q + IDX_W'(1);
            end
          end
        end
        default: state_q <= E_IDLE;
      endcase

      if (load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= err_q ? '0 : stk_rdata_i;
        out_last_q  <= !err_q && (j_q == last_idx_q);
        out_err_q   <= err_q;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lzw_decoder_top.sv]
// LZW decoder top level: chain walker, two-bank byte stack and byte emitter.
// Depends on lzw_pkg, lzw_ram, lzw_walker, lzw_emitter.
//
// Input stream: one 12-bit code per beat in s_axis_tdata[11:0]; s_axis_tuser
// set marks the first code of a stream and clears the dictionary first.
// Output stream: one decoded byte per beat in m_axis_tdata, m_axis_tlast on
// the final byte of each code's string. m_axis_tuser flags the single error
// beat (data and tlast zero) given for an undefined or overlong code.
// Timing: a code is taken, then its string of L bytes is rebuilt by walking
// the dictionary RAM one entry per cycle into a stack bank. A literal or
// repeat-of-previous code needs no length read; other dictionary codes first
// read their entry's length. Emission runs from the other stack bank at one
// byte per cycle while the receiver accepts, in parallel with the next walk.
// Reset: empty dictionary, no previous string, both streams idle. No
// clearing pass; dictionary data is only used from entries already written.
// Back-pressure: a stalled receiver holds the output register; the walker
// waits with a finished bank until the emitter is free, and s_axis_tready
// stays low meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module lzw_decoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [lzw_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [11:0] code
  input  logic                           s_axis_tuser,   // [0] start_req
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [lzw_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // [7:0] data_byte
  output logic                           m_axis_tlast,
  output logic                           m_axis_tuser    // [0] error
);
  import lzw_pkg::*;

  logic              stk_we;
  logic [STK_AW-1:0] stk_waddr;
  logic [BYTE_W-1:0] stk_wdata;
  logic [STK_AW-1:0] stk_raddr;
  logic [BYTE_W-1:0] stk_rdata;
  logic              job_valid;
  logic              job_ready;
  lzw_job_t          job;
  logic [BYTE_W-1:0] out_byte;

  lzw_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .code_i      (s_axis_tdata[CODE_W-1:0]),
    .start_i     (s_axis_tuser),
    .stk_we_o    (stk_we),
    .stk_waddr_o (stk_waddr),
    .stk_wdata_o (stk_wdata),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  lzw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  lzw_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .stk_raddr_o (stk_raddr),
    .stk_rdata_i (stk_rdata),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (out_byte),
    .m_last_o    (m_axis_tlast),
    .m_err_o     (m_axis_tuser)
  );

  assign m_axis_tdata = M_TDATA_W'(out_byte);

endmodule

`default_nettype wire

[hw/rtl/lzw_decoder_chk.sv]
// Port-level checker for the LZW decoder top level, with its bind.
// Depends on lzw_pkg, lzw_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

module lzw_decoder_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [lzw_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [lzw_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic                           m_axis_tlast,
  input logic                           m_axis_tuser
);
  import lzw_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input beat changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast && (m_axis_tdata == M_TDATA_W'(0)))
    else $error("error beat carries data or tlast");

  a_one_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second code taken while the first is being decoded");

  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

endmodule

bind lzw_decoder_top lzw_decoder_chk u_chk (.*);

`default_nettype wire
